>>> rtl/bba_pkg.sv
// Shared types, codes and defaults of the bitmap block allocator.
package bba_pkg;

   // Default sizing of the free bitmap
   localparam int MAX_BLOCKS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   // Field widths
   localparam int OPCODE_W   = 2;
   localparam int BLK_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Result field positions inside rsp_tdata
   localparam int RSP_BLK_LSB  = STATUS_W;
   localparam int RSP_FREE_BIT = STATUS_W + BLK_W;

   // Block count after reset
   localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

>>> rtl/bitmap_block_allocator_top.sv
// Bitmap free-block allocator: free bitmap in one synchronous RAM, read-modify-write control.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  req      | in        | req_tvalid / req_tready | tuser: opcode; tdata: block_number
//  rsp      | out       | rsp_tvalid / rsp_tready | tdata: status, allocated_block, is_free
//  csr      | in        | csr_wr_en               | csr_wr_data: total_blocks
//
// In-range query and free: the RAM read is issued at the accepting edge, an evaluate/
// write-back state and a load state follow, the response register is loaded with the
// result, and then the next request is taken. Refused, out-of-range and unused-opcode
// requests skip the read and go straight to the load state.
// Allocate reads one bitmap word per cycle until the first nonzero word or the last
// word covered by the effective block count, then goes to the load state.
// After reset a clearing pass writes zeros to all MAP_WORDS words; req_tready stays low
// meanwhile, csr writes are taken as ever.
// One request is in flight at a time; the next is taken while a response waits in the
// output register, and a stalled rsp side holds the finished result until taken.
module bitmap_block_allocator_top #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF, // blocks the bitmap can hold
   parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF   // bitmap word width, power of two
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bba_pkg::REQ_DATA_W-1:0]   req_tdata,   // [11:0] block_number, rest zero
   input  logic [bba_pkg::OPCODE_W-1:0]     req_tuser,   // [1:0] opcode
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bba_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [1:0] status, [13:2] allocated_block,
                                                         // [14] is_free, [15] zero
   // configuration
   input  logic                             csr_wr_en,
   input  logic [bba_pkg::CFG_W-1:0]        csr_wr_data  // total_blocks
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT_W    = ADDR_W + 1;
   localparam int WB_SH     = $clog2(WORD_BITS);
   localparam int IDX_W     = ADDR_W + WB_SH;
   localparam int CMP_W     = (IDX_W + 1 > bba_pkg::CFG_W) ? IDX_W + 1 : bba_pkg::CFG_W;

   // lowest set bit of a bitmap word
   function automatic logic [WB_SH-1:0] lsb_index(input logic [WORD_BITS-1:0] w);
      logic [WB_SH-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = WB_SH'(i);
         end
      end
      return pos;
   endfunction

   // Free bitmap RAM
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Control and request registers
   bba_pkg::state_type            state_ff, state_in;
   logic [WCNT_W-1:0]             scan_ff, scan_in;
   logic [bba_pkg::OPCODE_W-1:0]  op_ff, op_in;
   logic [bba_pkg::BLK_W-1:0]     blk_ff, blk_in;
   logic [bba_pkg::CFG_W-1:0]     total_ff;

   // Pending result
   logic [bba_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [bba_pkg::BLK_W-1:0]     res_block_ff, res_block_in;
   logic                          res_free_ff, res_free_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [bba_pkg::BLK_W-1:0]     rsp_block_ff;
   logic                          rsp_free_ff;
   logic                          rsp_load;

   // Derived request and limit values
   logic                          req_fire;
   logic [bba_pkg::BLK_W-1:0]     req_blk;
   logic [bba_pkg::OPCODE_W-1:0]  req_op;
   logic [ADDR_W-1:0]             req_word;
   logic [ADDR_W-1:0]             blk_word;
   logic [CMP_W-1:0]              limit_w;
   logic [CMP_W-1:0]              words_full;
   logic [WCNT_W-1:0]             words_w;
   logic                          req_in_range;
   logic                          req_to_scan;
   logic [WORD_BITS-1:0]          bit_mask;
   logic [WB_SH-1:0]              lsb_pos;
   logic [CMP_W-1:0]              found_idx;
   logic [WCNT_W-1:0]             scan_next;
   logic                          scan_last;
   logic                          clear_last;

   assign req_blk  = req_tdata[bba_pkg::BLK_W-1:0];
   assign req_op   = req_tuser;
   assign req_fire = req_tvalid && req_tready;

   // Bitmap word holding a block
   assign req_word = ADDR_W'(CMP_W'(req_blk) >> WB_SH);
   assign blk_word = ADDR_W'(CMP_W'(blk_ff) >> WB_SH);

   // Effective block count and the number of words it covers
   always_comb begin
      if (CMP_W'(total_ff) > CMP_W'(MAX_BLOCKS)) begin
         limit_w = CMP_W'(MAX_BLOCKS);
      end else begin
         limit_w = CMP_W'(total_ff);
      end
      words_full = (limit_w + CMP_W'(WORD_BITS - 1)) >> WB_SH;
      words_w    = words_full[WCNT_W-1:0];
   end

   assign req_in_range = CMP_W'(req_blk) < limit_w;

   // Whether an accepted request needs a bitmap read
   always_comb begin
      case (req_op)
         bba_pkg::OP_QUERY: req_to_scan = req_in_range;
         bba_pkg::OP_FREE:  req_to_scan = req_in_range && (req_blk != '0);
         bba_pkg::OP_ALLOC: req_to_scan = (words_w != '0);
         default:           req_to_scan = 1'b0;
      endcase
   end

   assign bit_mask   = WORD_BITS'(1) << blk_ff[WB_SH-1:0];
   assign lsb_pos    = lsb_index(rd_data_ff);
   assign found_idx  = CMP_W'({scan_ff[ADDR_W-1:0], lsb_pos});
   assign scan_next  = scan_ff + WCNT_W'(1);
   assign scan_last  = (scan_next == words_w);
   assign clear_last = (scan_ff == WCNT_W'(MAP_WORDS - 1));
   assign rsp_load   = (state_ff == bba_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = req_to_scan ? bba_pkg::ST_SCAN : bba_pkg::ST_DONE;
            end
         end
         bba_pkg::ST_SCAN: begin
            if (op_ff != bba_pkg::OP_ALLOC || rd_data_ff != '0 || scan_last) begin
               state_in = bba_pkg::ST_DONE;
            end
         end
         bba_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: state_in = bba_pkg::ST_CLEAR;
      endcase
   end

   // Datapath and RAM control per state
   always_comb begin
      req_tready    = 1'b0;
      rd_addr       = scan_ff[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = scan_ff[ADDR_W-1:0];
      wr_data       = '0;
      scan_in       = scan_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_free_in   = res_free_ff;
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            // zero one word a cycle
            wr_en   = 1'b1;
            scan_in = scan_next;
         end
         bba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // query and free read the block's word, allocate starts at word 0
            if (req_op == bba_pkg::OP_ALLOC) begin
               rd_addr = '0;
            end else begin
               rd_addr = req_word;
            end
            if (req_fire) begin
               op_in         = req_op;
               blk_in        = req_blk;
               scan_in       = '0;
               res_status_in = bba_pkg::STATUS_OK;
               res_block_in  = '0;
               res_free_in   = 1'b0;
               if (!req_to_scan) begin
                  if (req_op == bba_pkg::OP_FREE) begin
                     res_status_in = bba_pkg::STATUS_REFUSED;
                  end else if (req_op == bba_pkg::OP_ALLOC) begin
                     res_status_in = bba_pkg::STATUS_FULL;
                  end
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            case (op_ff)
               bba_pkg::OP_QUERY: begin
                  res_free_in = |(rd_data_ff & bit_mask);
               end
               bba_pkg::OP_FREE: begin
                  wr_en   = 1'b1;
                  wr_addr = blk_word;
                  wr_data = rd_data_ff | bit_mask;
               end
               bba_pkg::OP_ALLOC: begin
                  if (rd_data_ff != '0) begin
                     // first nonzero word decides, even if its bit lies past the limit
                     if (found_idx < limit_w) begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data_ff & (rd_data_ff - WORD_BITS'(1));
                        res_block_in  = found_idx[bba_pkg::BLK_W-1:0];
                     end else begin
                        res_status_in = bba_pkg::STATUS_FULL;
                     end
                  end else if (scan_last) begin
                     res_status_in = bba_pkg::STATUS_FULL;
                  end else begin
                     scan_in = scan_next;
                     rd_addr = scan_next[ADDR_W-1:0];
                  end
               end
               default: begin
                  res_status_in = bba_pkg::STATUS_OK;
               end
            endcase
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   // Response register next valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Bitmap RAM: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= bba_pkg::TOTAL_BLOCKS_RST;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_free_ff   <= res_free_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_free_ff   <= res_free_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_free_ff, rsp_block_ff, rsp_status_ff};

endmodule

>>> rtl/bba_checker.sv
// Port-level checks of the bitmap block allocator, bound to the top level.
module bba_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bba_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [bba_pkg::STATUS_W-1:0] rsp_status;
   logic [bba_pkg::BLK_W-1:0]    rsp_block;
   logic                         rsp_free;

   assign rsp_status = rsp_tdata[bba_pkg::STATUS_W-1:0];
   assign rsp_block  = rsp_tdata[bba_pkg::RSP_BLK_LSB +: bba_pkg::BLK_W];
   assign rsp_free   = rsp_tdata[bba_pkg::RSP_FREE_BIT];

   // clearing pass after reset: nothing taken, nothing shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or response shown right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // full or refused carries no block and no free flag
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != bba_pkg::STATUS_OK) |-> (rsp_block == '0) && !rsp_free)
      else $error("error response with nonzero fields");

   // a query answer showing a free block never comes with an allocated block
   a_query_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_free |-> (rsp_block == '0) && (rsp_status == bba_pkg::STATUS_OK))
      else $error("free flag mixed with allocation result");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);
